[hw/rtl/lzbd_pkg.sv]
// Shared types and constants for the LZ77 byte decompressor.
// Used by the front end, command queue, back end and top level.
package lzbd_pkg;

    localparam int HISTORY_DEPTH    = 256;
    localparam int BYTES_PER_RESULT = 4;
    localparam int QUEUE_DEPTH      = 4;
    localparam int QUEUE_AW         = $clog2(QUEUE_DEPTH);
    localparam int LANE_W           = $clog2(BYTES_PER_RESULT);
    localparam int COUNT_W          = 3;
    localparam int SEEN_W           = 9;
    localparam logic [SEEN_W-1:0] SEEN_MAX = 9'd256;
    localparam logic [2:0] HDR_BYTES = 3'd4;
    localparam logic [7:0] TAG_MATCH = 8'h00;

    localparam logic [1:0] STAT_OK         = 2'd0;
    localparam logic [1:0] STAT_HDR_SHORT  = 2'd1;
    localparam logic [1:0] STAT_SIZE_SHORT = 2'd2;
    localparam logic [1:0] STAT_BAD_DIST   = 2'd3;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_LIT,
        KIND_COPY
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        logic [7:0] len;
        logic       last;
        logic [1:0] status;
    } t_cmd;

    typedef struct packed {
        logic [31:0]        bytes;
        logic [COUNT_W-1:0] count;
        logic               run_last;
        logic               done;
        logic [1:0]         status;
    } t_result;

endpackage

[hw/rtl/lzbd_front.sv]
// Front end: parses header and tokens, tracks size and distance limits,
// and issues one command per byte that produces output or ends the stream.
// Depends on lzbd_pkg.
module lzbd_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [7:0]    i_byte,
    input  logic          i_last,
    output logic          o_push,
    output lzbd_pkg::t_cmd o_cmd
);

    typedef enum logic [1:0] {
        PH_TAG,
        PH_LIT,
        PH_DIST,
        PH_LEN
    } t_phase;

    t_phase                      r_phase, n_phase;
    logic [2:0]                  r_hdr_cnt, n_hdr_cnt;
    logic [31:0]                 r_left, n_left;
    logic [lzbd_pkg::SEEN_W-1:0] r_seen, n_seen;
    logic [7:0]                  r_lit_left, n_lit_left;
    logic [7:0]                  r_dist, n_dist;
    logic                        r_err, n_err;

    logic [7:0]                  add_cnt;
    logic [lzbd_pkg::SEEN_W:0]   seen_sum;
    logic                        emit;

    always_comb begin
        n_phase    = r_phase;
        n_hdr_cnt  = r_hdr_cnt;
        n_left     = r_left;
        n_seen     = r_seen;
        n_lit_left = r_lit_left;
        n_dist     = r_dist;
        n_err      = r_err;
        add_cnt    = '0;
        emit       = 1'b0;
        o_push     = 1'b0;
        o_cmd      = '{kind: lzbd_pkg::KIND_NONE, data: i_byte, len: 8'd0,
                       last: i_last, status: lzbd_pkg::STAT_OK};
        if (i_accept) begin
            if (r_hdr_cnt < lzbd_pkg::HDR_BYTES) begin
                case (r_hdr_cnt[1:0])
                    2'd0: n_left[7:0]   = i_byte;
                    2'd1: n_left[15:8]  = i_byte;
                    2'd2: n_left[23:16] = i_byte;
                    default: n_left[31:24] = i_byte;
                endcase
                n_hdr_cnt = r_hdr_cnt + 3'd1;
            end else if (r_left != 32'd0) begin
                case (r_phase)
                    PH_TAG: begin
                        if (i_byte == lzbd_pkg::TAG_MATCH) begin
                            n_phase = PH_DIST;
                        end else begin
                            n_lit_left = i_byte;
                            n_phase    = PH_LIT;
                        end
                    end
                    PH_LIT: begin
                        emit       = 1'b1;
                        o_cmd.kind = lzbd_pkg::KIND_LIT;
                        add_cnt    = 8'd1;
                        n_lit_left = r_lit_left - 8'd1;
                        if (r_lit_left == 8'd1) begin
                            n_phase = PH_TAG;
                        end
                    end
                    PH_DIST: begin
                        n_dist  = i_byte;
                        n_phase = PH_LEN;
                    end
                    PH_LEN: begin
                        n_phase = PH_TAG;
                        if (i_byte != 8'd0) begin
                            if (r_dist == 8'd0 || {1'b0, r_dist} > r_seen) begin
                                n_err = 1'b1;
                            end else begin
                                emit       = 1'b1;
                                o_cmd.kind = lzbd_pkg::KIND_COPY;
                                o_cmd.data = r_dist;
                                add_cnt    = (r_left < {24'd0, i_byte}) ? r_left[7:0] : i_byte;
                                o_cmd.len  = add_cnt;
                            end
                        end
                    end
                    default: n_phase = PH_TAG;
                endcase
                n_left = r_left - {24'd0, add_cnt};
            end
            seen_sum = {1'b0, r_seen} + {{(lzbd_pkg::SEEN_W - 7){1'b0}}, add_cnt};
            if (emit) begin
                n_seen = (seen_sum > {1'b0, lzbd_pkg::SEEN_MAX}) ? lzbd_pkg::SEEN_MAX
                                                             : seen_sum[lzbd_pkg::SEEN_W-1:0];
            end
            if (i_last) begin
                o_push = 1'b1;
                if (n_hdr_cnt < lzbd_pkg::HDR_BYTES) begin
                    o_cmd.status = lzbd_pkg::STAT_HDR_SHORT;
                end else if (n_err) begin
                    o_cmd.status = lzbd_pkg::STAT_BAD_DIST;
                end else if (n_left != 32'd0) begin
                    o_cmd.status = lzbd_pkg::STAT_SIZE_SHORT;
                end
                n_phase    = PH_TAG;
                n_hdr_cnt  = '0;
                n_left     = '0;
                n_seen     = '0;
                n_lit_left = '0;
                n_dist     = '0;
                n_err      = 1'b0;
            end else begin
                o_push = emit;
            end
        end else begin
            seen_sum = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_TAG;
            r_hdr_cnt  <= '0;
            r_left     <= '0;
            r_seen     <= '0;
            r_lit_left <= '0;
            r_dist     <= '0;
            r_err      <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_hdr_cnt  <= n_hdr_cnt;
            r_left     <= n_left;
            r_seen     <= n_seen;
            r_lit_left <= n_lit_left;
            r_dist     <= n_dist;
            r_err      <= n_err;
        end
    end

endmodule

[hw/rtl/lzbd_cmd_queue.sv]
// Short command queue between front and back end.
// Depends on lzbd_pkg.
module lzbd_cmd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  lzbd_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output lzbd_pkg::t_cmd o_cmd
);

    lzbd_pkg::t_cmd                  r_slot [lzbd_pkg::QUEUE_DEPTH];
    logic [lzbd_pkg::QUEUE_AW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [lzbd_pkg::QUEUE_AW:0]     r_count;

    assign o_full  = (r_count == (lzbd_pkg::QUEUE_AW + 1)'(lzbd_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[hw/rtl/lzbd_back.sv]
// Back end: runs literal and copy commands against the history memory
// and packs decoded bytes into results held in an output register.
// Depends on lzbd_pkg.
module lzbd_back #(
    parameter int HISTORY_DEPTH = lzbd_pkg::HISTORY_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    input  lzbd_pkg::t_cmd    i_cmd,
    output logic              o_pop,
    output logic              o_res_valid,
    output lzbd_pkg::t_result o_res,
    input  logic              i_res_ready
);

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam int BPR = lzbd_pkg::BYTES_PER_RESULT;
    localparam int LW = lzbd_pkg::LANE_W;

    typedef enum logic {
        S_IDLE,
        S_COPY
    } t_state;

    logic [7:0]  r_mem [HISTORY_DEPTH];
    logic [7:0]  r_mem_q;

    t_state            r_state, n_state;
    logic [AW-1:0]     r_wptr, n_wptr;
    logic [AW-1:0]     r_src, n_src;
    logic [7:0]        r_issue, n_issue;
    logic [7:0]        r_rem, n_rem;
    logic              r_rd_v, n_rd_v;
    logic              r_fwd, n_fwd;
    logic [7:0]        r_fwd_data, n_fwd_data;
    logic [31:0]       r_acc, n_acc;
    logic [LW-1:0]     r_acc_cnt, n_acc_cnt;
    logic              r_clast, n_clast;
    logic [1:0]        r_cstat, n_cstat;
    logic              r_out_v, n_out_v;
    lzbd_pkg::t_result r_out, n_out;

    logic        out_free;
    logic        mem_we;
    logic [7:0]  mem_wdata;
    logic        rd_en;
    logic [7:0]  cp_byte;
    logic        last_byte;
    logic        flush;
    logic        adv;
    logic [31:0] word;

    assign out_free    = !r_out_v || i_res_ready;
    assign o_res_valid = r_out_v;
    assign o_res       = r_out;
    assign cp_byte     = r_fwd ? r_fwd_data : r_mem_q;
    assign last_byte   = (r_rem == 8'd1);
    assign flush       = r_rd_v && ((r_acc_cnt == LW'(BPR - 1)) || last_byte);
    assign adv         = !flush || out_free;

    always_comb begin
        word = r_acc;
        for (int l = 0; l < BPR; l++) begin
            if (r_acc_cnt == LW'(l)) begin
                word[8*l +: 8] = cp_byte;
            end
        end
    end

    always_comb begin
        n_state    = r_state;
        n_wptr     = r_wptr;
        n_src      = r_src;
        n_issue    = r_issue;
        n_rem      = r_rem;
        n_rd_v     = r_rd_v;
        n_fwd      = r_fwd;
        n_fwd_data = r_fwd_data;
        n_acc      = r_acc;
        n_acc_cnt  = r_acc_cnt;
        n_clast    = r_clast;
        n_cstat    = r_cstat;
        n_out      = r_out;
        n_out_v    = r_out_v && !i_res_ready;
        o_pop      = 1'b0;
        mem_we     = 1'b0;
        mem_wdata  = cp_byte;
        rd_en      = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && (i_cmd.kind == lzbd_pkg::KIND_COPY || out_free)) begin
                    o_pop = 1'b1;
                    case (i_cmd.kind)
                        lzbd_pkg::KIND_COPY: begin
                            n_state   = S_COPY;
                            n_issue   = i_cmd.len;
                            n_rem     = i_cmd.len;
                            n_src     = r_wptr - AW'(i_cmd.data);
                            n_rd_v    = 1'b0;
                            n_fwd     = 1'b0;
                            n_acc     = '0;
                            n_acc_cnt = '0;
                            n_clast   = i_cmd.last;
                            n_cstat   = i_cmd.status;
                        end
                        lzbd_pkg::KIND_LIT: begin
                            mem_we    = 1'b1;
                            mem_wdata = i_cmd.data;
                            n_wptr    = i_cmd.last ? '0 : r_wptr + 1'b1;
                            n_out_v   = 1'b1;
                            n_out     = '{bytes: {24'd0, i_cmd.data},
                                          count: lzbd_pkg::COUNT_W'(1), run_last: 1'b1,
                                          done: i_cmd.last, status: i_cmd.status};
                        end
                        default: begin
                            if (i_cmd.last) begin
                                n_wptr = '0;
                            end
                            n_out_v = 1'b1;
                            n_out   = '{bytes: 32'd0, count: '0, run_last: 1'b1,
                                        done: i_cmd.last, status: i_cmd.status};
                        end
                    endcase
                end
            end
            S_COPY: begin
                if (adv) begin
                    if (r_rd_v) begin
                        mem_we = 1'b1;
                        n_wptr = (last_byte && r_clast) ? '0 : r_wptr + 1'b1;
                        n_rem  = r_rem - 8'd1;
                        if (flush) begin
                            n_out_v   = 1'b1;
                            n_out     = '{bytes: word,
                                          count: lzbd_pkg::COUNT_W'(r_acc_cnt) + 1'b1,
                                          run_last: last_byte,
                                          done: last_byte && r_clast,
                                          status: last_byte ? r_cstat : lzbd_pkg::STAT_OK};
                            n_acc     = '0;
                            n_acc_cnt = '0;
                        end else begin
                            n_acc     = word;
                            n_acc_cnt = r_acc_cnt + 1'b1;
                        end
                        if (last_byte) begin
                            n_state = S_IDLE;
                        end
                    end
                    if (r_issue != 8'd0) begin
                        rd_en      = 1'b1;
                        n_src      = r_src + 1'b1;
                        n_issue    = r_issue - 8'd1;
                        n_rd_v     = 1'b1;
                        n_fwd      = r_rd_v && (r_wptr == r_src);
                        n_fwd_data = cp_byte;
                    end else begin
                        n_rd_v = 1'b0;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_wptr] <= mem_wdata;
        end
        if (rd_en) begin
            r_mem_q <= r_mem[r_src];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_wptr     <= '0;
            r_src      <= '0;
            r_issue    <= '0;
            r_rem      <= '0;
            r_rd_v     <= 1'b0;
            r_fwd      <= 1'b0;
            r_acc      <= '0;
            r_acc_cnt  <= '0;
            r_clast    <= 1'b0;
            r_cstat    <= lzbd_pkg::STAT_OK;
            r_out_v    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_wptr     <= n_wptr;
            r_src      <= n_src;
            r_issue    <= n_issue;
            r_rem      <= n_rem;
            r_rd_v     <= n_rd_v;
            r_fwd      <= n_fwd;
            r_acc      <= n_acc;
            r_acc_cnt  <= n_acc_cnt;
            r_clast    <= n_clast;
            r_cstat    <= n_cstat;
            r_out_v    <= n_out_v;
        end
        r_fwd_data <= n_fwd_data;
        r_out      <= n_out;
    end

endmodule

[hw/rtl/lz77_byte_decompressor.sv]
// LZ77 byte decompressor top level: front end, command queue, back end.
// Path: a literal or final byte passes the command queue and output register; a match
// passes the queue, the history read register and the byte packing into the output register.
// Throughput: header and literal bytes 1 per cycle; a match holds the back end until all
// its bytes are written; input flows on while the 4-entry command queue has room.
// Reset: synchronous, active low; clears control state, history left as is.
module lz77_byte_decompressor #(
    parameter int HISTORY_DEPTH = lzbd_pkg::HISTORY_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] out_bytes, [34:32] out_count, rest 0
    output logic        m_axis_tlast,
    output logic [2:0]  m_axis_tuser    // [0] stream_done, [2:1] stream_status
);

    logic              in_accept;
    logic              push;
    logic              full;
    logic              pop;
    logic              q_valid;
    lzbd_pkg::t_cmd    push_cmd;
    lzbd_pkg::t_cmd    q_cmd;
    lzbd_pkg::t_result res;

    assign s_axis_tready = !full;
    assign in_accept     = s_axis_tvalid && !full;

    lzbd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_byte   (s_axis_tdata),
        .i_last   (s_axis_tlast),
        .o_push   (push),
        .o_cmd    (push_cmd)
    );

    lzbd_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    lzbd_back #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_pop       (pop),
        .o_res_valid (m_axis_tvalid),
        .o_res       (res),
        .i_res_ready (m_axis_tready)
    );

    assign m_axis_tdata = {5'd0, res.count, res.bytes};
    assign m_axis_tlast = res.run_last;
    assign m_axis_tuser = {res.status, res.done};

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[34:32] <= 3'd4)
        else $error("result byte count above four");

    a_done_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast)
        else $error("stream end not on last result of its byte");

    a_status_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tuser[2:1] == lzbd_pkg::STAT_OK)
        else $error("status set on a result that does not end the stream");

    a_full_mid_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[34:32] == 3'd4)
        else $error("partial result inside a run");

endmodule
